// ===== hdl/nearest_palette_color_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the nearest palette color block
// Short forms for clocked implications with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define NPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("npc assertion failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("npc assertion failed");

`endif

// ===== hdl/npc_pkg.sv =====
// ---------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the nearest palette color block.
// ---------------------------------------------------------------------------
package npc_pkg;

  localparam int MaxEntriesDefault = 256;

  localparam int CountW = 9;
  localparam int DistW  = 18;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  // Commands carried in the cmd field
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_PALETTE_COUNT = 1'b0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [7:0]       best_index;
    logic [7:0]       best_red;
    logic [7:0]       best_green;
    logic [7:0]       best_blue;
    logic [DistW-1:0] best_dist_sq;
  } out_item_t;

  // Palette write broadcast to every cell
  typedef struct packed {
    logic       valid;
    logic [7:0] index;
    color_t     color;
  } load_t;

  // Query token that walks down the cell chain
  typedef struct packed {
    color_t           query;
    logic             found;
    logic [7:0]       best_index;
    color_t           best_color;
    logic [DistW-1:0] best_dist;
  } tok_t;

endpackage

// ===== hdl/nearest_palette_color.sv =====
// ---------------------------------------------------------------------------
// nearest_palette_color
// Palette of RGB colors with a nearest-color search by squared distance.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o  | npc_pkg::in_item_t
//   out     | output    | out_valid_o / out_ready_i| npc_pkg::out_item_t
//   cfg     | input     | APB psel/penable/pready  | palette_count at 0x0
//
// A load is written into its slot's cell at the accept edge and the input
// stays ready. A query's accept edge loads the token into the first cell;
// the token walks the chain of MAX_ENTRIES cells one cell per cycle, then
// passes a pending register and the output register before its result
// turns valid. The input is ready again in the cycle the result turns
// valid, so the next query is not taken before the last one's result.
// Reset clears the count and all control state; palette slots hold no reset
// value. While a query is in flight the input is held not ready. A result
// waiting in the output register does not block the next item; a second
// finished query waits in the pending register and holds the input off until
// the output drains.
// ---------------------------------------------------------------------------
module nearest_palette_color #(
  parameter int MAX_ENTRIES = npc_pkg::MaxEntriesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  npc_pkg::in_item_t         in_item_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output npc_pkg::out_item_t        out_item_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [npc_pkg::AddrW-1:0] paddr,
  input  logic [npc_pkg::DataW-1:0] pwdata,
  output logic [npc_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  logic [npc_pkg::CountW-1:0] count;
  logic                       in_fire;
  npc_pkg::load_t             load;

  logic                       tok_valid [0:MAX_ENTRIES];
  npc_pkg::tok_t              tok       [0:MAX_ENTRIES];

  logic                       busy_d, busy_q;
  logic                       pend_valid_d, pend_valid_q;
  npc_pkg::out_item_t         pend_q;
  logic                       out_valid_d, out_valid_q;
  npc_pkg::out_item_t         out_q;
  logic                       pend_move;

  npc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .count_o (count)
  );

  // Hold the input off while a query walks the chain, so loads cannot race it
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // Broadcast a load to every cell; only the addressed slot takes it
  always_comb begin
    load.valid       = in_fire && (in_item_i.cmd == npc_pkg::CMD_LOAD);
    load.index       = in_item_i.entry_index;
    load.color.red   = in_item_i.red;
    load.color.green = in_item_i.green;
    load.color.blue  = in_item_i.blue;
  end

  // Launch a fresh token at the head of the chain on a query
  always_comb begin
    tok_valid[0]       = in_fire && (in_item_i.cmd == npc_pkg::CMD_QUERY);
    tok[0].query.red   = in_item_i.red;
    tok[0].query.green = in_item_i.green;
    tok[0].query.blue  = in_item_i.blue;
    tok[0].found       = 1'b0;
    tok[0].best_index  = '0;
    tok[0].best_color  = '0;
    tok[0].best_dist   = '0;
  end

  // Chain of cells: cell k reads token k and hands token k+1 to its neighbor
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    npc_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .count_i     (count),
      .tok_valid_i (tok_valid[k]),
      .tok_i       (tok[k]),
      .tok_valid_o (tok_valid[k+1]),
      .tok_o       (tok[k+1])
    );
  end

  // Advance the pending result once the output register is free or drains
  assign pend_move = pend_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    busy_d       = busy_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;
    if (tok_valid[0]) begin
      busy_d = 1'b1;
    end
    if (tok_valid[MAX_ENTRIES]) begin
      pend_valid_d = 1'b1;
    end
    if (pend_move) begin
      pend_valid_d = 1'b0;
      out_valid_d  = 1'b1;
      busy_d       = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Pack the tail token into a result item
  always_ff @(posedge clk_i) begin
    if (tok_valid[MAX_ENTRIES]) begin
      pend_q.found        <= tok[MAX_ENTRIES].found;
      pend_q.best_index   <= tok[MAX_ENTRIES].best_index;
      pend_q.best_red     <= tok[MAX_ENTRIES].best_color.red;
      pend_q.best_green   <= tok[MAX_ENTRIES].best_color.green;
      pend_q.best_blue    <= tok[MAX_ENTRIES].best_color.blue;
      pend_q.best_dist_sq <= tok[MAX_ENTRIES].best_dist;
    end
    if (pend_move) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/npc_cfg.sv =====
// ---------------------------------------------------------------------------
// npc_cfg
// APB register file holding the palette entry count.
// ---------------------------------------------------------------------------
module npc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [npc_pkg::AddrW-1:0]  paddr,
  input  logic [npc_pkg::DataW-1:0]  pwdata,
  output logic [npc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [npc_pkg::CountW-1:0] count_o
);

  logic [npc_pkg::CountW-1:0] count_d, count_q;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == npc_pkg::REG_PALETTE_COUNT);

  always_comb begin
    count_d = count_q;
    if (wr_en) begin
      count_d = pwdata[npc_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == npc_pkg::REG_PALETTE_COUNT) begin
      prdata = npc_pkg::DataW'(count_q);
    end
  end

  assign count_o = count_q;

endmodule

// ===== hdl/npc_cell.sv =====
// ---------------------------------------------------------------------------
// npc_cell
// One palette slot: holds its color and updates the passing query token.
// ---------------------------------------------------------------------------
module npc_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  npc_pkg::load_t             load_i,
  input  logic [npc_pkg::CountW-1:0] count_i,
  input  logic                       tok_valid_i,
  input  npc_pkg::tok_t              tok_i,
  output logic                       tok_valid_o,
  output npc_pkg::tok_t              tok_o
);

  localparam logic [7:0] Slot = 8'(CELL_IDX);

  npc_pkg::color_t             entry_q;
  npc_pkg::tok_t               tok_d, tok_q;
  logic                        valid_q;
  logic                        in_use;
  logic                        better;
  logic [npc_pkg::DistW-1:0]   cand_dist;

  function automatic logic [15:0] sq_diff(logic [7:0] a, logic [7:0] b);
    logic [7:0] m;
    m = (a >= b) ? (a - b) : (b - a);
    return 16'(m) * 16'(m);
  endfunction

  // Capture a load addressed to this slot
  always_ff @(posedge clk_i) begin
    if (load_i.valid && (32'(load_i.index) == CELL_IDX)) begin
      entry_q <= load_i.color;
    end
  end

  assign in_use    = (32'(count_i) > CELL_IDX);
  assign cand_dist = npc_pkg::DistW'(sq_diff(entry_q.red,   tok_i.query.red))
                   + npc_pkg::DistW'(sq_diff(entry_q.green, tok_i.query.green))
                   + npc_pkg::DistW'(sq_diff(entry_q.blue,  tok_i.query.blue));
  // Strict compare keeps the earlier slot on a tie
  assign better = in_use && (!tok_i.found || (cand_dist < tok_i.best_dist));

  always_comb begin
    tok_d = tok_i;
    if (better) begin
      tok_d.found      = 1'b1;
      tok_d.best_index = Slot;
      tok_d.best_color = entry_q;
      tok_d.best_dist  = cand_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

endmodule

// ===== hdl/npc_checker.sv =====
// ---------------------------------------------------------------------------
// npc_checker
// Port-level assertions for the nearest palette color block.
// ---------------------------------------------------------------------------
`include "nearest_palette_color_macros.svh"

module npc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input npc_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input npc_pkg::out_item_t out_item_o
);

  logic query_fire;
  logic load_fire;

  assign query_fire = in_valid_i && in_ready_o && (in_item_i.cmd == npc_pkg::CMD_QUERY);
  assign load_fire  = in_valid_i && in_ready_o && (in_item_i.cmd == npc_pkg::CMD_LOAD);

  // Stalled result holds
  `NPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

  // An empty search reports an all-zero item
  `NPC_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_valid_o && !out_item_o.found, (out_item_o.best_index == 8'd0) && (out_item_o.best_red == 8'd0) && (out_item_o.best_green == 8'd0) && (out_item_o.best_blue == 8'd0) && (out_item_o.best_dist_sq == '0))

  // A query occupies the chain
  `NPC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_fire, !in_ready_o)

  // A load leaves the block free for the next item
  `NPC_ASSERT_NEXT(a_load_free, clk_i, rst_ni, load_fire, in_ready_o)

endmodule

bind nearest_palette_color npc_checker u_npc_checker (.*);
